>>> design/icvp_pkg.sv
// ----------------------------------------------------------------------------
// icvp_pkg
// Shared types, codes and tables of the intra coefficient VLC packer.
// ----------------------------------------------------------------------------
package icvp_pkg;

    // Token opcodes
    typedef enum logic [2:0] {
        OP_MB_START = 3'd0,
        OP_DC       = 3'd1,
        OP_AC_ESC   = 3'd2,
        OP_EOB      = 3'd3,
        OP_FLUSH    = 3'd4
    } t_opcode;

    // Register indexes
    localparam int unsigned REG_SIGNED_OUTPUT = 0;

    localparam logic [11:0] PRED_RESET   = 12'sd512;
    localparam logic [11:0] DC_BIAS      = 12'sd1024;
    localparam logic [12:0] DIFF_MAX     = 13'sd2047;
    localparam logic [31:0] MARKER_WORD  = 32'hFF00_0000;
    localparam logic [23:0] ESC_PREFIX   = 24'h04_0000;
    localparam logic [23:0] EOB_CODE     = 24'h00_0002;
    localparam logic [5:0]  WORD_BITS    = 6'd32;

    // Swap the four bytes of a word
    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Luma DC size code
    function automatic logic [9:0] lum_code(input logic [3:0] size);
        case (size)
            4'd0:    return 10'h004;
            4'd1:    return 10'h000;
            4'd2:    return 10'h001;
            4'd3:    return 10'h005;
            4'd4:    return 10'h006;
            4'd5:    return 10'h00E;
            4'd6:    return 10'h01E;
            4'd7:    return 10'h03E;
            4'd8:    return 10'h07E;
            4'd9:    return 10'h0FE;
            4'd10:   return 10'h1FE;
            default: return 10'h1FF;
        endcase
    endfunction

    function automatic logic [3:0] lum_len(input logic [3:0] size);
        case (size)
            4'd0:    return 4'd3;
            4'd1:    return 4'd2;
            4'd2:    return 4'd2;
            4'd3:    return 4'd3;
            4'd4:    return 4'd3;
            4'd5:    return 4'd4;
            4'd6:    return 4'd5;
            4'd7:    return 4'd6;
            4'd8:    return 4'd7;
            4'd9:    return 4'd8;
            default: return 4'd9;
        endcase
    endfunction

    // Chroma DC size code
    function automatic logic [9:0] chr_code(input logic [3:0] size);
        case (size)
            4'd0:    return 10'h000;
            4'd1:    return 10'h001;
            4'd2:    return 10'h002;
            4'd3:    return 10'h006;
            4'd4:    return 10'h00E;
            4'd5:    return 10'h01E;
            4'd6:    return 10'h03E;
            4'd7:    return 10'h07E;
            4'd8:    return 10'h0FE;
            4'd9:    return 10'h1FE;
            4'd10:   return 10'h3FE;
            default: return 10'h3FF;
        endcase
    endfunction

    function automatic logic [3:0] chr_len(input logic [3:0] size);
        case (size)
            4'd0:    return 4'd2;
            4'd1:    return 4'd2;
            4'd2:    return 4'd2;
            4'd3:    return 4'd3;
            4'd4:    return 4'd4;
            4'd5:    return 4'd5;
            4'd6:    return 4'd6;
            4'd7:    return 4'd7;
            4'd8:    return 4'd8;
            4'd9:    return 4'd9;
            default: return 4'd10;
        endcase
    endfunction

endpackage

>>> design/intra_coefficient_vlc_packer.sv
// ----------------------------------------------------------------------------
// intra_coefficient_vlc_packer
// Turns intra coefficient tokens into a packed, byte-swapped VLC word stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one token per request:
//   macroblock start, DC coefficient, AC escape, end of block or flush.
//   Output channel (o_valid / i_stall) carries 32-bit stream words, MSB-first
//   packed and byte-swapped; o_last_word marks the final word of a token.
//   The APB port holds signed_output at address 0.
// Throughput:
//   A token is coded in the cycle it is accepted; its word, if any, is on
//   the output in the next cycle. One token per cycle is taken while words
//   are drained. A flush gives 3 to 7 words, one per unstalled cycle from the
//   output register; the next token is held off until its last word is taken.
// Reset:
//   Empties the accumulator, sets the DC predictors to 512, clears the word
//   count and the output register, and selects unsigned output.
// Receiver stall:
//   The output word holds; the input stalls while a word waits, unless that
//   word is the last of its token and is taken in the same cycle.
// ----------------------------------------------------------------------------
module intra_coefficient_vlc_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // token input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [1:0]  i_component,
    input  logic signed [10:0] i_dc_value,
    input  logic [5:0]  i_run,
    input  logic signed [11:0] i_level,
    // word output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_stream_word,
    output logic        o_last_word,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic              r_signed_output;
    logic [31:0]       r_acc;
    logic [5:0]        r_free;
    logic [11:0]       r_pred [3];
    logic [1:0]        r_wmf;

    logic              r_out_valid;
    logic [31:0]       r_out_word;
    logic              r_out_last;
    logic [2:0]        r_tail_idx;
    logic [2:0]        r_tail_left;

    logic in_fire;
    logic out_take;

    // Hand the output to the receiver
    assign o_valid       = r_out_valid;
    assign o_stream_word = r_out_word;
    assign o_last_word   = r_out_last;

    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_out_valid && !(out_take && (r_tail_left == 3'd0));
    assign in_fire  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic reg_sel;
    assign reg_sel = (paddr[2] == 1'(icvp_pkg::REG_SIGNED_OUTPUT));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, r_signed_output} : 32'd0;

    // ------------------------------------------------------------------
    // DC differential coding
    // ------------------------------------------------------------------
    logic [1:0]         dc_comp;
    logic signed [11:0] dc_biased;
    logic signed [11:0] dc_half;
    logic signed [11:0] dc_pred;
    logic signed [12:0] dc_diff_raw;
    logic signed [11:0] dc_diff;
    logic [11:0]        dc_mag;
    logic [3:0]         dc_size;
    logic [11:0]        dc_bits;
    logic [10:0]        dc_mask;
    logic [9:0]         dc_scode;
    logic [3:0]         dc_slen;
    logic [23:0]        dc_val;
    logic [4:0]         dc_n;

    always_comb begin
        // Component three shares the Cr predictor
        dc_comp     = (i_component == 2'd3) ? 2'd2 : i_component;
        dc_biased   = $signed({i_dc_value[10], i_dc_value})
                    + (r_signed_output ? 12'sd0 : $signed(icvp_pkg::DC_BIAS));
        dc_half     = dc_biased >>> 1;
        dc_pred     = $signed(r_pred[dc_comp]);
        dc_diff_raw = $signed({dc_half[11], dc_half}) - $signed({dc_pred[11], dc_pred});
        // Clamp the difference to +-2047
        if (dc_diff_raw > $signed(icvp_pkg::DIFF_MAX)) begin
            dc_diff = 12'sd2047;
        end else if (dc_diff_raw < -$signed(icvp_pkg::DIFF_MAX)) begin
            dc_diff = -12'sd2047;
        end else begin
            dc_diff = dc_diff_raw[11:0];
        end
        dc_mag  = dc_diff[11] ? 12'(-dc_diff) : 12'(dc_diff);
        // Bit length of the magnitude
        dc_size = 4'd0;
        for (int b = 0; b < 11; b++) begin
            if (dc_mag[b]) begin
                dc_size = 4'(b + 1);
            end
        end
        // Ones' complement for negative differences
        dc_bits  = dc_diff[11] ? 12'(dc_diff - 12'sd1) : 12'(dc_diff);
        dc_mask  = 11'((12'd1 << dc_size) - 12'd1);
        if (dc_comp != 2'd0) begin
            dc_scode = icvp_pkg::chr_code(dc_size);
            dc_slen  = icvp_pkg::chr_len(dc_size);
        end else begin
            dc_scode = icvp_pkg::lum_code(dc_size);
            dc_slen  = icvp_pkg::lum_len(dc_size);
        end
        dc_val = (24'(dc_scode) << dc_size) | 24'(dc_bits[10:0] & dc_mask);
        dc_n   = 5'(dc_slen) + 5'(dc_size);
    end

    // ------------------------------------------------------------------
    // Token to code selection
    // ------------------------------------------------------------------
    logic        put_en;
    logic [23:0] put_val;
    logic [4:0]  put_n;
    logic        is_flush;
    logic        is_mb;
    logic        is_dc;

    always_comb begin
        put_en   = 1'b0;
        put_val  = 24'd0;
        put_n    = 5'd1;
        is_flush = 1'b0;
        is_mb    = 1'b0;
        is_dc    = 1'b0;
        case (i_opcode)
            icvp_pkg::OP_MB_START: begin
                put_en  = 1'b1;
                put_val = 24'd1;
                put_n   = 5'd1;
                is_mb   = 1'b1;
            end
            icvp_pkg::OP_DC: begin
                put_en  = 1'b1;
                put_val = dc_val;
                put_n   = dc_n;
                is_dc   = 1'b1;
            end
            icvp_pkg::OP_AC_ESC: begin
                put_en  = 1'b1;
                put_val = icvp_pkg::ESC_PREFIX | {6'd0, i_run, i_level};
                put_n   = 5'd24;
            end
            icvp_pkg::OP_EOB: begin
                put_en  = 1'b1;
                put_val = icvp_pkg::EOB_CODE;
                put_n   = 5'd2;
            end
            icvp_pkg::OP_FLUSH: begin
                is_flush = 1'b1;
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bit packer
    // ------------------------------------------------------------------
    logic [31:0] pk_val;
    logic [5:0]  pk_n;
    logic        pk_fits;
    logic [5:0]  pk_free_fit;
    logic [5:0]  pk_over;
    logic [5:0]  pk_free_spill;
    logic [31:0] pk_word;

    always_comb begin
        pk_val        = 32'(put_val);
        pk_n          = 6'(put_n);
        pk_fits       = (pk_n <= r_free);
        pk_free_fit   = r_free - pk_n;
        pk_over       = pk_n - r_free;
        pk_free_spill = icvp_pkg::WORD_BITS - pk_over;
        pk_word       = r_acc | (pk_val >> pk_over);
    end

    // ------------------------------------------------------------------
    // Flush sequence sizing
    // ------------------------------------------------------------------
    logic       fl_partial;
    logic [1:0] fl_pad;
    logic [2:0] fl_count;

    always_comb begin
        fl_partial = (r_free != icvp_pkg::WORD_BITS);
        fl_pad     = 2'd0 - (r_wmf + 2'(fl_partial) + 2'd3);
        fl_count   = 3'(fl_partial) + 3'd3 + 3'(fl_pad);
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic [31:0] n_acc;
    logic [5:0]  n_free;
    logic [1:0]  n_wmf;
    logic        n_has_word;
    logic [31:0] n_first_word;
    logic [2:0]  n_tail_idx;
    logic [2:0]  n_tail_left;

    always_comb begin
        n_acc        = r_acc;
        n_free       = r_free;
        n_wmf        = r_wmf;
        n_has_word   = 1'b0;
        n_first_word = pk_word;
        n_tail_idx   = 3'd0;
        n_tail_left  = 3'd0;
        if (is_flush) begin
            n_acc        = 32'd0;
            n_free       = icvp_pkg::WORD_BITS;
            n_wmf        = 2'd0;
            n_has_word   = 1'b1;
            n_first_word = fl_partial ? icvp_pkg::swap32(r_acc) : 32'd0;
            n_tail_idx   = fl_partial ? 3'd0 : 3'd1;
            n_tail_left  = fl_count - 3'd1;
        end else if (put_en) begin
            if (pk_fits) begin
                n_free = pk_free_fit;
                n_acc  = r_acc | (pk_val << pk_free_fit);
            end else begin
                n_free       = pk_free_spill;
                n_acc        = pk_val << pk_free_spill;
                n_wmf        = r_wmf + 2'd1;
                n_has_word   = 1'b1;
                n_first_word = icvp_pkg::swap32(pk_word);
            end
        end
    end

    // ------------------------------------------------------------------
    // Packer state, predictors and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_output <= 1'b0;
            r_acc           <= 32'd0;
            r_free          <= icvp_pkg::WORD_BITS;
            r_wmf           <= 2'd0;
            for (int c = 0; c < 3; c++) begin
                r_pred[c] <= icvp_pkg::PRED_RESET;
            end
        end else begin
            if (psel && penable && pwrite && reg_sel) begin
                r_signed_output <= pwdata[0];
            end
            if (in_fire) begin
                r_acc  <= n_acc;
                r_free <= n_free;
                r_wmf  <= n_wmf;
                if (is_mb) begin
                    for (int c = 0; c < 3; c++) begin
                        r_pred[c] <= icvp_pkg::PRED_RESET;
                    end
                end else if (is_dc) begin
                    r_pred[dc_comp] <= dc_half;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and flush word sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_tail_idx  <= 3'd0;
            r_tail_left <= 3'd0;
        end else begin
            // Advance through a flush sequence, or drop the taken word
            if (out_take) begin
                if (r_tail_left != 3'd0) begin
                    r_out_word  <= (r_tail_idx == 3'd1) ?
                                   icvp_pkg::swap32(icvp_pkg::MARKER_WORD) : 32'd0;
                    r_tail_idx  <= r_tail_idx + 3'd1;
                    r_tail_left <= r_tail_left - 3'd1;
                    r_out_last  <= (r_tail_left == 3'd1);
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
            // Load the first word of a new request
            if (in_fire && n_has_word) begin
                r_out_valid <= 1'b1;
                r_out_word  <= n_first_word;
                r_out_last  <= (n_tail_left == 3'd0);
                r_tail_idx  <= n_tail_idx;
                r_tail_left <= n_tail_left;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_tail_left == 3'd0)))
        else $error("last flag out of step with remaining flush words");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= icvp_pkg::WORD_BITS)
        else $error("free bit count above word size");

    a_flush_aligns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_opcode == icvp_pkg::OP_FLUSH)) |=>
            ((r_wmf == 2'd0) && (r_free == icvp_pkg::WORD_BITS) && r_out_valid))
        else $error("flush left stream unaligned or accumulator not empty");

    a_sequence_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && (r_tail_left != 3'd0)) |=> r_out_valid)
        else $error("flush sequence ended early");

    a_no_accept_mid_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_tail_left != 3'd0)) |-> !in_fire)
        else $error("request accepted during flush sequence");

endmodule
